// File: sv/pserl_pkg.sv
// ----------------------------------------------------------------------------
// pserl_pkg: shared types and constants of the per-source error rate limiter
// Payload structs, the token that travels along the slot chain, register
// indexes, action codes and the register defaults.
// ----------------------------------------------------------------------------
package pserl_pkg;

    localparam int SOURCE_SLOTS = 16;
    localparam int SLOT_W       = $clog2(SOURCE_SLOTS + 1);   // width of the slot_index field
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MUTED          = 2'd3;

    // register defaults, also stored on a write of zero
    localparam logic [15:0] DEF_FULL_LIMIT = 16'd5;
    localparam logic [31:0] DEF_MIN_GAP    = 32'd1000;
    localparam logic [31:0] DEF_SUMMARY    = 32'd30000;

    // action codes
    localparam logic [2:0] ACT_FULL    = 3'd0;
    localparam logic [2:0] ACT_NOTICE  = 3'd1;
    localparam logic [2:0] ACT_SUMMARY = 3'd2;
    localparam logic [2:0] ACT_SILENT  = 3'd3;
    localparam logic [2:0] ACT_MUTED   = 3'd4;

    typedef struct packed {
        logic [31:0] source_key;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0]       suppressed_count;
        logic [31:0]       elapsed_ms;
    } out_t;

    typedef struct packed {
        logic [15:0] full_limit;
        logic [31:0] full_gap;
        logic [31:0] summary_period_ms;
    } cfg_t;

    // event token handed from cell to cell
    typedef struct packed {
        logic        busy;   // an event occupies this hop
        logic        done;   // a slot already took the event
        logic [31:0] key;
        logic [31:0] now;
        out_t        res;
    } token_t;

endpackage

// File: sv/pserl_cell.sv
// ----------------------------------------------------------------------------
// pserl_cell: one source slot of the limiter chain
// Holds one slot's key and counters. Takes the passing event on a key match,
// on a free slot, or unconditionally when it is the overflow cell.
// ----------------------------------------------------------------------------
module pserl_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pserl_pkg::cfg_t               cfg,
    input  logic [pserl_pkg::SLOT_W-1:0]  slot_id,
    input  logic                          last,
    input  pserl_pkg::token_t             tok_in,
    output pserl_pkg::token_t             tok_out
);

    logic        valid_reg,  valid_next;
    logic [31:0] key_reg,    key_next;
    logic [15:0] fc_reg,     fc_next;
    logic [31:0] supp_reg,   supp_next;
    logic [31:0] lf_reg,     lf_next;
    logic [31:0] ls_reg,     ls_next;
    logic        notice_reg, notice_next;
    pserl_pkg::token_t tok_reg, tok_next;

    logic        take;
    logic [15:0] cur_fc;
    logic [31:0] cur_supp, cur_lf, cur_ls, supp_inc, el_full, el_sum;
    logic        cur_notice, allow_full;

    assign take = tok_in.busy && !tok_in.done &&
                  (!valid_reg || last || (key_reg == tok_in.key));

    // a slot being claimed starts from cleared counters
    assign cur_fc     = valid_reg ? fc_reg     : 16'd0;
    assign cur_supp   = valid_reg ? supp_reg   : 32'd0;
    assign cur_lf     = valid_reg ? lf_reg     : 32'd0;
    assign cur_ls     = valid_reg ? ls_reg     : 32'd0;
    assign cur_notice = valid_reg ? notice_reg : 1'b0;

    assign el_full  = tok_in.now - cur_lf;
    assign el_sum   = tok_in.now - cur_ls;
    assign supp_inc = cur_supp + 32'd1;
    assign allow_full = (cur_fc < cfg.full_limit) &&
                        ((cur_fc == 16'd0) || (el_full >= cfg.full_gap));

    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        fc_next     = fc_reg;
        supp_next   = supp_reg;
        lf_next     = lf_reg;
        ls_next     = ls_reg;
        notice_next = notice_reg;
        tok_next    = tok_in;
        if (take)
        begin
            valid_next  = 1'b1;
            key_next    = tok_in.key;
            fc_next     = cur_fc;
            supp_next   = cur_supp;
            lf_next     = cur_lf;
            ls_next     = cur_ls;
            notice_next = cur_notice;
            tok_next.done           = 1'b1;
            tok_next.res.slot_index = slot_id;
            tok_next.res.suppressed_count = 32'd0;
            tok_next.res.elapsed_ms       = 32'd0;
            if (allow_full)
            begin
                fc_next = (cur_fc == 16'hFFFF) ? cur_fc : cur_fc + 16'd1;
                lf_next = tok_in.now;
                tok_next.res.action = pserl_pkg::ACT_FULL;
            end
            else if (!cur_notice)
            begin
                supp_next   = supp_inc;
                notice_next = 1'b1;
                ls_next     = tok_in.now;
                tok_next.res.action = pserl_pkg::ACT_NOTICE;
            end
            else if ((el_sum >= cfg.summary_period_ms) && (supp_inc != 32'd0))
            begin
                supp_next = 32'd0;
                ls_next   = tok_in.now;
                tok_next.res.action           = pserl_pkg::ACT_SUMMARY;
                tok_next.res.suppressed_count = supp_inc;
                tok_next.res.elapsed_ms       = el_sum;
            end
            else
            begin
                supp_next = supp_inc;
                tok_next.res.action = pserl_pkg::ACT_SILENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            key_reg     <= '0;
            fc_reg      <= '0;
            supp_reg    <= '0;
            lf_reg      <= '0;
            ls_reg      <= '0;
            notice_reg  <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            key_reg     <= key_next;
            fc_reg      <= fc_next;
            supp_reg    <= supp_next;
            lf_reg      <= lf_next;
            ls_reg      <= ls_next;
            notice_reg  <= notice_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: sv/per_source_error_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_error_rate_limiter: per-source error log limiter
// Each error event (source key, ms timestamp) is answered by exactly one
// result: full message, one-time suppression notice, periodic summary with
// suppressed count and elapsed ms, silent suppression, or muted drop. The
// block handles one event at a time: the event walks a chain of 16 source
// slot cells plus one shared overflow cell, one cell per clock, then passes a
// pending register and then the output register. The input reopens as the
// result moves from the pending register to the output register, so no new
// event is taken while the last one is still in the chain or pending. A
// muted event skips the chain and goes straight to the pending register.
// Output stalls hold the pending result and so delay both paths.
// Slots are claimed lowest first and never released; sources beyond the 16
// slots share the overflow slot (slot_index 16). Registers may be written
// only while the block is idle; writing zero to a limit or period register
// stores its default.
// ----------------------------------------------------------------------------
module per_source_error_rate_limiter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pserl_pkg::in_t                   in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pserl_pkg::out_t                  out_data,
    input  logic                             cfg_we,
    input  logic [pserl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pserl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NCELL = pserl_pkg::SOURCE_SLOTS + 1;

    // configuration
    pserl_pkg::cfg_t cfg_reg, cfg_next;
    logic            muted_reg, muted_next;

    // control
    logic            busy_reg, busy_next;
    logic            pend_valid_reg, pend_valid_next;
    pserl_pkg::out_t pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    pserl_pkg::out_t out_reg, out_next;

    logic in_xfer, pend_move;

    // tok[i] feeds cell i; tok[NCELL] leaves the overflow cell
    pserl_pkg::token_t tok [NCELL+1];
    pserl_pkg::token_t tok_head;

    assign in_ready  = !busy_reg;
    assign in_xfer   = in_valid && in_ready;
    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);

    // inject the event at the head of the chain unless muted
    always_comb
    begin
        tok_head      = '0;
        tok_head.busy = in_xfer && !muted_reg;
        tok_head.key  = in_data.source_key;
        tok_head.now  = in_data.now_ms;
    end

    assign tok[0] = tok_head;

    // slot cells 0..SOURCE_SLOTS-1, then the overflow cell that always takes
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        pserl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg_reg),
            .slot_id (pserl_pkg::SLOT_W'(i)),
            .last    (i == NCELL - 1),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // register writes; zero in a limit or period stores its default
    always_comb
    begin
        cfg_next   = cfg_reg;
        muted_next = muted_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pserl_pkg::REG_FULL_LIMIT:
                    cfg_next.full_limit = (cfg_data[15:0] == 16'd0) ?
                        pserl_pkg::DEF_FULL_LIMIT : cfg_data[15:0];
                pserl_pkg::REG_MIN_GAP_MS:
                    cfg_next.full_gap = (cfg_data == 32'd0) ?
                        pserl_pkg::DEF_MIN_GAP : cfg_data;
                pserl_pkg::REG_SUMMARY_PERIOD:
                    cfg_next.summary_period_ms = (cfg_data == 32'd0) ?
                        pserl_pkg::DEF_SUMMARY : cfg_data;
                pserl_pkg::REG_MUTED:
                    muted_next = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // result path: chain end or muted drop -> pending -> output register
    always_comb
    begin
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (pend_move)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end

        if (in_xfer)
        begin
            busy_next = 1'b1;
            if (muted_reg)
            begin
                pend_valid_next = 1'b1;
                pend_next       = '0;
                pend_next.action = pserl_pkg::ACT_MUTED;
            end
        end
        if (tok[NCELL].busy)
        begin
            pend_valid_next = 1'b1;
            pend_next       = tok[NCELL].res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_limit        <= pserl_pkg::DEF_FULL_LIMIT;
            cfg_reg.full_gap          <= pserl_pkg::DEF_MIN_GAP;
            cfg_reg.summary_period_ms <= pserl_pkg::DEF_SUMMARY;
            muted_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            muted_reg      <= muted_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // the pending slot is empty whenever an event leaves the chain
    a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok[NCELL].busy |-> !pend_valid_reg)
        else $error("chain result landed on a full pending register");

    // a pending result always belongs to the event in flight
    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> busy_reg)
        else $error("pending result without an event in flight");

    // one event at a time: an input transfer closes the input
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input reopened right after a transfer");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for per_source_error_rate_limiter
// Error events go in over a valid/ready channel and are scored against an
// in-bench rate-limit predictor, field by field, in transfer order. Phases
// change the registers while the block is idle, and both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSLOT       = pserl_pkg::SOURCE_SLOTS + 1;
    localparam int OVF_SLOT    = pserl_pkg::SOURCE_SLOTS;   // shared slot for sources with no slot
    localparam int TAIL_CYCLES = 25;             // settle time at the end of wait_idle
    localparam int HOLD_CYCLES = 400;            // long sink hold-off
    localparam int NUM_HOT     = 3;              // keys that take most of the traffic
    localparam int NUM_KEYS    = 12;             // keys that own slots for good

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    pserl_pkg::in_t                   in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    pserl_pkg::out_t                  out_data;
    logic                             cfg_we    = 1'b0;
    logic [pserl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pserl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    per_source_error_rate_limiter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the limiter registers and slot table
    // ------------------------------------------------------------------
    logic [15:0] lim_full;
    logic [31:0] lim_gap;
    logic [31:0] lim_period;
    logic        lim_muted;

    logic        slot_used    [NSLOT];
    logic [31:0] slot_owner   [pserl_pkg::SOURCE_SLOTS];
    logic [15:0] fulls_sent   [NSLOT];
    logic [31:0] supp_total   [NSLOT];
    logic [31:0] full_stamp   [NSLOT];
    logic [31:0] last_note_ms [NSLOT];   // last notice or summary time
    logic        notice_sent  [NSLOT];

    pserl_pkg::in_t  pending_events[$];      // stimulus not yet offered
    pserl_pkg::out_t expected_actions[$];    // predicted results, oldest first

    // transfer seen by the driver, registered and handed to the monitor in the next cycle
    logic           took_event = 1'b0;
    pserl_pkg::in_t took_data  = '0;

    int unsigned     n_accepted = 0;
    int unsigned     send_wait  = 0;
    int unsigned     stall_left = 0;
    int unsigned     hold_left  = 0;
    int unsigned     hold_at    = 300;
    int unsigned     mismatches = 0;
    pserl_pkg::out_t due;

    logic [31:0] clock_ms;               // running time base for random events
    logic [31:0] step_max;               // typical time step in the current phase
    bit          quiet_bus = 1'b0;       // phase without any idling on either side
    logic [31:0] known_keys [NUM_KEYS];

    // Decide the outcome of one event and update the slot table, the way the
    // block does: match, else lowest free slot, else the shared overflow slot.
    function automatic pserl_pkg::out_t limit_decision(pserl_pkg::in_t ev);
        pserl_pkg::out_t r;
        int              s;
        int              free_s;
        bit              claim;
        logic [31:0]     since;
        r = '0;
        if (lim_muted)
        begin
            // muted drop: no slot, no state change, all other fields zero
            r.action = pserl_pkg::ACT_MUTED;
            return r;
        end
        s      = -1;
        free_s = -1;
        for (int i = 0; i < pserl_pkg::SOURCE_SLOTS; i++)
        begin
            if (slot_used[i])
            begin
                if (s < 0 && slot_owner[i] == ev.source_key)
                    s = i;
            end
            else if (free_s < 0)
            begin
                free_s = i;
            end
        end
        claim = 1'b0;
        if (s < 0)
        begin
            s     = (free_s < 0) ? OVF_SLOT : free_s;
            claim = !slot_used[s];       // overflow slot is cleared on first use only
            if (s != OVF_SLOT)
                slot_owner[s] = ev.source_key;
            slot_used[s] = 1'b1;
        end
        if (claim)
        begin
            fulls_sent[s]   = '0;
            supp_total[s]   = '0;
            full_stamp[s]   = '0;
            last_note_ms[s] = '0;
            notice_sent[s]  = 1'b0;
        end

        since = ev.now_ms - full_stamp[s];
        if (fulls_sent[s] < lim_full && (fulls_sent[s] == 16'd0 || since >= lim_gap))
        begin
            if (fulls_sent[s] != 16'hFFFF)
                fulls_sent[s] = fulls_sent[s] + 16'd1;
            full_stamp[s] = ev.now_ms;
            r.action = pserl_pkg::ACT_FULL;
        end
        else
        begin
            supp_total[s] = supp_total[s] + 32'd1;
            since = ev.now_ms - last_note_ms[s];
            if (!notice_sent[s])
            begin
                notice_sent[s]  = 1'b1;
                last_note_ms[s] = ev.now_ms;
                r.action = pserl_pkg::ACT_NOTICE;
            end
            else if (since >= lim_period && supp_total[s] != 32'd0)
            begin
                r.action           = pserl_pkg::ACT_SUMMARY;
                r.suppressed_count = supp_total[s];
                r.elapsed_ms       = since;
                supp_total[s]      = '0;
                last_note_ms[s]    = ev.now_ms;
            end
            else
            begin
                r.action = pserl_pkg::ACT_SILENT;
            end
        end
        r.slot_index = pserl_pkg::SLOT_W'(s);
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(20, 4);
        return $urandom_range(120, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued events; a gap is drawn after each transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            took_event <= 1'b0;
            send_wait  <= 0;
        end
        else
        begin
            took_event <= in_valid && in_ready;
            took_data  <= in_data;
            if (in_valid && in_ready)
                n_accepted <= n_accepted + 1;
            // payload only moves once the current event has been taken
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    in_data   <= pending_events.pop_front();
                    send_wait <= quiet_bus ? 0 : idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long sink hold-off, counted here; it fires as the transfer count passes
    // each threshold, while the sender keeps offering, so the block backs up.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (rst_n && n_accepted >= hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_at   <= hold_at + 350;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts each transfer, scores results, drives out_ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        // prediction and scoring share this process, so their order is fixed
        if (took_event)
            expected_actions.push_back(limit_decision(took_data));
        if (out_valid && out_ready)
        begin
            if (expected_actions.size() == 0)
            begin
                $error("result with no event outstanding: action %0d slot %0d",
                       out_data.action, out_data.slot_index);
                mismatches++;
            end
            else
            begin
                due = expected_actions.pop_front();
                if (out_data.action != due.action)
                begin
                    $error("action: expected %0d, got %0d", due.action, out_data.action);
                    mismatches++;
                end
                if (out_data.slot_index != due.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d",
                           due.slot_index, out_data.slot_index);
                    mismatches++;
                end
                if (out_data.suppressed_count != due.suppressed_count)
                begin
                    $error("suppressed_count: expected %0d, got %0d",
                           due.suppressed_count, out_data.suppressed_count);
                    mismatches++;
                end
                if (out_data.elapsed_ms != due.elapsed_ms)
                begin
                    $error("elapsed_ms: expected %0d, got %0d",
                           due.elapsed_ms, out_data.elapsed_ms);
                    mismatches++;
                end
            end
        end

        if (!rst_n || hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet_bus && $urandom_range(4, 0) == 0)
                stall_left <= idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (run from the sequencing block, on falling edges)
    // ------------------------------------------------------------------
    task automatic offer(input logic [31:0] key, input logic [31:0] now);
        pserl_pkg::in_t ev;
        ev.source_key = key;
        ev.now_ms     = now;
        pending_events.push_back(ev);
    endtask

    // Wait until every event has gone through and every result is scored,
    // then let the pipeline settle before any register is touched.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || in_valid || took_event ||
               expected_actions.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Register write; the predictor copy follows the same zero-means-default
    // and masking rules as the hardware.
    task automatic write_reg(input logic [pserl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            pserl_pkg::REG_FULL_LIMIT:
                lim_full   = (val[15:0] != 16'd0) ? val[15:0] : pserl_pkg::DEF_FULL_LIMIT;
            pserl_pkg::REG_MIN_GAP_MS:
                lim_gap    = (val != 32'd0) ? val : pserl_pkg::DEF_MIN_GAP;
            pserl_pkg::REG_SUMMARY_PERIOD:
                lim_period = (val != 32'd0) ? val : pserl_pkg::DEF_SUMMARY;
            pserl_pkg::REG_MUTED:
                lim_muted  = val[0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random events: most traffic on a few hot keys so that slots walk through
    // notice, silent and summary; some on the other slot owners; a few fresh
    // keys that fill the table and then share the overflow slot.
    task automatic queue_events(input int n);
        pserl_pkg::in_t ev;
        int unsigned    pick;
        repeat (n)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 60)
                ev.source_key = known_keys[$urandom_range(NUM_HOT - 1, 0)];
            else if (pick < 90)
                ev.source_key = known_keys[$urandom_range(NUM_KEYS - 1, 0)];
            else
                ev.source_key = $urandom;
            pick = $urandom_range(99, 0);
            if (pick < 3)
            begin
                ev.now_ms = $urandom;           // stray stamp, time base untouched
            end
            else
            begin
                if (pick < 75)
                    clock_ms = clock_ms + $urandom_range(step_max, 0);
                else if (pick < 97)
                    clock_ms = clock_ms + $urandom_range(40 * step_max, step_max);
                else
                    clock_ms = clock_ms + $urandom;   // big jump, wraps the time base
                ev.now_ms = clock_ms;
            end
            pending_events.push_back(ev);
        end
    endtask

    task automatic run_phase(input logic [31:0] limit, input logic [31:0] gap,
                             input logic [31:0] period, input int n,
                             input logic [31:0] step, input bit quiet);
        wait_idle();
        write_reg(pserl_pkg::REG_FULL_LIMIT, limit);
        write_reg(pserl_pkg::REG_MIN_GAP_MS, gap);
        write_reg(pserl_pkg::REG_SUMMARY_PERIOD, period);
        step_max  = step;
        quiet_bus = quiet;
        queue_events(n);
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_used[i]    = 1'b0;
            fulls_sent[i]   = '0;
            supp_total[i]   = '0;
            full_stamp[i]   = '0;
            last_note_ms[i] = '0;
            notice_sent[i]  = 1'b0;
            if (i < pserl_pkg::SOURCE_SLOTS)
                slot_owner[i] = '0;
        end
        lim_full   = pserl_pkg::DEF_FULL_LIMIT;
        lim_gap    = pserl_pkg::DEF_MIN_GAP;
        lim_period = pserl_pkg::DEF_SUMMARY;
        lim_muted  = 1'b0;

        // extreme keys own the first slots; the zero key is matched like any
        known_keys[0] = 32'hFFFF_FFFF;
        known_keys[1] = 32'h0000_0000;
        known_keys[2] = 32'h0000_0001;
        for (int i = 3; i < NUM_KEYS; i++)
            known_keys[i] = $urandom;
        clock_ms = $urandom;
        step_max = 100;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset defaults (limit 5, gap 1000, period 30000).
        offer(32'hFFFF_FFFF, 32'd0);            // first event of a source: full
        offer(32'hFFFF_FFFF, 32'd5);            // inside min gap: notice
        offer(32'hFFFF_FFFF, 32'd6);            // silent
        offer(32'hFFFF_FFFF, 32'd30005);        // gap met: full
        offer(32'hFFFF_FFFF, 32'd30010);        // period met: summary of 3
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);    // full at the top of the range
        offer(32'hFFFF_FFFF, 32'd998);          // time wrapped, gap 999: suppressed
        offer(32'hFFFF_FFFF, 32'd999);          // gap exactly 1000 across the wrap: full
        offer(32'hFFFF_FFFF, 32'd5000);         // fifth full reaches the limit
        offer(32'hFFFF_FFFF, 32'd10000);        // over the count limit: suppressed
        offer(32'h0000_0000, 32'h8000_0000);    // zero key claims a slot
        offer(32'h0000_0000, 32'h8000_0001);    // and gets its own notice
        offer(32'h0000_0001, 32'hFFFF_FFFF);

        // Zero writes restore defaults; muted events leave the table alone.
        wait_idle();
        write_reg(pserl_pkg::REG_FULL_LIMIT, 32'd0);
        write_reg(pserl_pkg::REG_MIN_GAP_MS, 32'd0);
        write_reg(pserl_pkg::REG_SUMMARY_PERIOD, 32'd0);
        write_reg(pserl_pkg::REG_MUTED, 32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF, 32'd20000);
        offer($urandom, $urandom);
        offer(32'h0000_0000, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(pserl_pkg::REG_MUTED, 32'hFFFF_FFFE);    // only bit 0 counts

        // Random phases over a range of settings, extremes included.
        run_phase(32'd1, 32'd1, 32'd1, 120, 32'd4, 1'b0);
        run_phase(32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 120, 32'd3000, 1'b1);
        run_phase(32'hABCD_0003, 32'd50, 32'd400, 250, 32'd100, 1'b0);

        wait_idle();
        write_reg(pserl_pkg::REG_MUTED, 32'd1);
        quiet_bus = 1'b0;
        queue_events(20);
        wait_idle();
        write_reg(pserl_pkg::REG_MUTED, 32'd0);

        run_phase($urandom_range(8, 1), $urandom_range(200, 1), $urandom_range(2000, 1),
                  280, 32'd300, 1'b0);
        // low half zero on the limit write, so all three go back to defaults
        run_phase(32'h0001_0000, 32'd0, 32'd0, 140, 32'd5000, 1'b0);

        wait_idle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
